// ----- hdl/vgfd_pkg.sv -----
// Shared types and codes for the voxel gradient unit.
package vgfd_pkg;

  // Sample word width (signed Q16.16).
  localparam int DATA_W = 32;

  // Operation codes carried by in_op.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SIZE_X      = 3'd0,
    CFG_SIZE_Y      = 3'd1,
    CFG_SIZE_Z      = 3'd2,
    CFG_INV_SPACE_X = 3'd3,
    CFG_INV_SPACE_Y = 3'd4,
    CFG_INV_SPACE_Z = 3'd5
  } cfg_index_t;

  // Axis tags.
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Control that travels alongside one difference through the scaler.
  typedef struct packed {
    logic  valid;
    axis_t axis;
    logic  sh17;   // central difference: extra halving
    logic  zero;   // axis of size one: force zero
  } scale_ctl_t;

endpackage

// ----- hdl/vgfd_sample_mem.sv -----
// Single-port sample memory with registered read data.
module vgfd_sample_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 addr,
  input  logic [vgfd_pkg::DATA_W-1:0]   wdata,
  output logic [vgfd_pkg::DATA_W-1:0]   rdata
);

  logic [vgfd_pkg::DATA_W-1:0] mem_q [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[addr] <= wdata;
    end else begin
      rdata <= mem_q[addr];
    end
  end

endmodule

// ----- hdl/vgfd_scale.sv -----
// Scaling pipeline: magnitude, multiply by reciprocal spacing, shift and saturate.
module vgfd_scale (
  input  logic                     clk,
  input  logic                     rst_n,
  input  vgfd_pkg::scale_ctl_t     ctl_i,
  input  logic signed [32:0]       diff_i,
  input  logic [31:0]              inv_i,
  output vgfd_pkg::scale_ctl_t     ctl_o,
  output logic signed [31:0]       value_o
);

  vgfd_pkg::scale_ctl_t ctl1_r, ctl2_r, ctl3_r;
  logic [31:0]          mag_r;
  logic                 neg1_r, neg2_r;
  logic [31:0]          inv_r;
  logic [63:0]          prod_r;
  logic signed [31:0]   value_r;

  logic signed [32:0]   neg_diff;
  logic [47:0]          shifted;
  logic [31:0]          sat_mag;
  logic signed [31:0]   value_nxt;

  assign neg_diff = -diff_i;

  // Saturate the truncated product and apply the sign
  always_comb begin
    shifted   = ctl2_r.sh17 ? 48'(prod_r >> 17) : 48'(prod_r >> 16);
    sat_mag   = shifted[31:0];
    value_nxt = '0;
    if (ctl2_r.zero) begin
      value_nxt = '0;
    end else if (!neg2_r) begin
      if (shifted > 48'h0000_7FFF_FFFF) begin
        sat_mag = 32'h7FFF_FFFF;
      end
      value_nxt = signed'(sat_mag);
    end else begin
      if (shifted > 48'h0000_8000_0000) begin
        sat_mag = 32'h8000_0000;
      end
      value_nxt = signed'(32'd0 - sat_mag);
    end
  end

  // Advance control through the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    neg1_r  <= diff_i[32];
    mag_r   <= diff_i[32] ? neg_diff[31:0] : diff_i[31:0];
    inv_r   <= inv_i;
    neg2_r  <= neg1_r;
    prod_r  <= 64'(mag_r) * 64'(inv_r);
    value_r <= value_nxt;
  end

  assign ctl_o   = ctl3_r;
  assign value_o = value_r;

endmodule

// ----- hdl/voxel_gradient_finite_difference_top.sv -----
// Top level of the voxel gradient unit: registers, read sequencer and result collection.
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+----------------------------
//  input    | in_op in_pos_x/y/z in_comp in_sample           | start & !busy
//  result   | out_grad_x/y/z out_pos_error                   | out_valid, one cycle strobe
//  config   | cfg_index cfg_data                             | cfg_valid & cfg_ready
//
//  A write beat is accepted, then occupies the sample memory port in the write state.
//  An out-of-range query strobes its result the cycle after accept.
//  An in-range query issues six reads through the single memory port, one per cycle,
//  then passes the difference, magnitude, multiply and saturate stages.
//  Reset clears control state and the registers to size 1 and spacing 1.0; the
//  sample memory is not cleared. The receiver cannot stall; results are never held.
module voxel_gradient_finite_difference_top #(
  parameter int MAX_SIZE   = 16,
  parameter int COMPONENTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [3:0]         in_pos_x,
  input  logic [3:0]         in_pos_y,
  input  logic [3:0]         in_pos_z,
  input  logic [1:0]         in_comp,
  input  logic signed [31:0] in_sample,
  output logic               out_valid,
  output logic signed [31:0] out_grad_x,
  output logic signed [31:0] out_grad_y,
  output logic signed [31:0] out_grad_z,
  output logic               out_pos_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int CW    = $clog2(MAX_SIZE);
  localparam int DEPTH = MAX_SIZE * MAX_SIZE * MAX_SIZE * COMPONENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SZW   = ($clog2(MAX_SIZE + 1) > 5) ? $clog2(MAX_SIZE + 1) : 5;
  localparam logic [2:0] LAST_STEP = 3'd5;

  typedef enum logic [1:0] {ST_IDLE, ST_WRITE, ST_READ, ST_DRAIN} state_t;

  // Configuration registers
  logic [4:0]  size_r [3];
  logic [31:0] inv_r  [3];

  // Item and sequencer registers
  state_t             state_r;
  logic [2:0]         step_r;
  logic [3:0]         pos_r [3];
  logic [1:0]         comp_r;
  logic [AW-1:0]      wr_addr_r;
  logic [31:0]        wr_data_r;
  logic               rd_pend_r;
  logic [2:0]         rd_step_r;
  logic [31:0]        hi_r;
  logic signed [32:0] diff_r;
  vgfd_pkg::scale_ctl_t dctl_r;

  // Output registers
  logic               out_valid_r;
  logic signed [31:0] grad_x_r, grad_y_r, grad_z_r;
  logic               pos_error_r;
  logic signed [31:0] part_x_r, part_y_r;

  logic               accept;
  logic [SZW-1:0]     eff [3];
  logic               wr_ok;
  logic               qry_err;
  logic               first_a [3];
  logic               last_a  [3];
  logic               zero_a  [3];
  logic               sh17_a  [3];
  logic [CW-1:0]      hi_c [3];
  logic [CW-1:0]      lo_c [3];
  logic [CW-1:0]      coord [3];
  logic [1:0]         issue_ax;
  vgfd_pkg::axis_t    rd_ax;
  logic               rd_sh17, rd_zero;
  logic [31:0]        sel_inv;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [31:0]        mem_rdata;
  vgfd_pkg::scale_ctl_t sc_ctl;
  logic signed [31:0] sc_value;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                             input logic [CW-1:0] z, input logic [1:0] c);
    return ((AW'(z) * AW'(MAX_SIZE) + AW'(y)) * AW'(MAX_SIZE) + AW'(x)) * AW'(COMPONENTS)
           + AW'(c);
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Clamp sizes to the store dimension
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      eff[a] = (SZW'(size_r[a]) > SZW'(MAX_SIZE)) ? SZW'(MAX_SIZE) : SZW'(size_r[a]);
    end
  end

  // Range checks on the incoming beat
  assign wr_ok = (SZW'(in_pos_x) < SZW'(MAX_SIZE)) && (SZW'(in_pos_y) < SZW'(MAX_SIZE)) &&
                 (SZW'(in_pos_z) < SZW'(MAX_SIZE)) && (5'(in_comp) < 5'(COMPONENTS));
  assign qry_err = (SZW'(in_pos_x) >= eff[0]) || (SZW'(in_pos_y) >= eff[1]) ||
                   (SZW'(in_pos_z) >= eff[2]) || (5'(in_comp) >= 5'(COMPONENTS));

  // Neighbor coordinates and difference form per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      first_a[a] = (pos_r[a] == 4'd0);
      last_a[a]  = (SZW'(pos_r[a]) == eff[a] - SZW'(1));
      zero_a[a]  = (eff[a] <= SZW'(1));
      sh17_a[a]  = !first_a[a] && !last_a[a];
      hi_c[a]    = (last_a[a] && !first_a[a]) ? CW'(pos_r[a]) : CW'(5'(pos_r[a]) + 5'd1);
      lo_c[a]    = first_a[a] ? CW'(pos_r[a]) : CW'(5'(pos_r[a]) - 5'd1);
    end
  end

  // Pick the neighbor for the current read step: even steps high side, odd low side
  assign issue_ax = step_r[2:1];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      coord[a] = (issue_ax == 2'(a)) ? (step_r[0] ? lo_c[a] : hi_c[a]) : CW'(pos_r[a]);
    end
  end

  assign mem_we   = (state_r == ST_WRITE);
  assign mem_addr = mem_we ? wr_addr_r : addr_of(coord[0], coord[1], coord[2], comp_r);

  vgfd_sample_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (wr_data_r),
    .rdata (mem_rdata)
  );

  // Select per-axis form and spacing for data coming back
  assign rd_ax = vgfd_pkg::axis_t'(rd_step_r[2:1]);
  always_comb begin
    unique case (rd_ax)
      vgfd_pkg::AXIS_X: begin rd_sh17 = sh17_a[0]; rd_zero = zero_a[0]; end
      vgfd_pkg::AXIS_Y: begin rd_sh17 = sh17_a[1]; rd_zero = zero_a[1]; end
      vgfd_pkg::AXIS_Z: begin rd_sh17 = sh17_a[2]; rd_zero = zero_a[2]; end
      default:          begin rd_sh17 = 1'b0;      rd_zero = 1'b1;      end
    endcase
  end

  always_comb begin
    unique case (dctl_r.axis)
      vgfd_pkg::AXIS_X: sel_inv = inv_r[0];
      vgfd_pkg::AXIS_Y: sel_inv = inv_r[1];
      vgfd_pkg::AXIS_Z: sel_inv = inv_r[2];
      default:          sel_inv = '0;
    endcase
  end

  vgfd_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (dctl_r),
    .diff_i  (diff_r),
    .inv_i   (sel_inv),
    .ctl_o   (sc_ctl),
    .value_o (sc_value)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        size_r[a] <= 5'd1;
        inv_r[a]  <= 32'h0001_0000;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vgfd_pkg::CFG_SIZE_X:      size_r[0] <= cfg_data[4:0];
        vgfd_pkg::CFG_SIZE_Y:      size_r[1] <= cfg_data[4:0];
        vgfd_pkg::CFG_SIZE_Z:      size_r[2] <= cfg_data[4:0];
        vgfd_pkg::CFG_INV_SPACE_X: inv_r[0]  <= cfg_data;
        vgfd_pkg::CFG_INV_SPACE_Y: inv_r[1]  <= cfg_data;
        vgfd_pkg::CFG_INV_SPACE_Z: inv_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r[0]  <= in_pos_x;
      pos_r[1]  <= in_pos_y;
      pos_r[2]  <= in_pos_z;
      comp_r    <= in_comp;
      wr_addr_r <= addr_of(CW'(in_pos_x), CW'(in_pos_y), CW'(in_pos_z), in_comp);
      wr_data_r <= in_sample;
    end
  end

  // Track reads in flight and form differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      dctl_r    <= '0;
    end else begin
      rd_pend_r    <= (state_r == ST_READ);
      dctl_r.valid <= rd_pend_r && rd_step_r[0];
      dctl_r.axis  <= rd_ax;
      dctl_r.sh17  <= rd_sh17;
      dctl_r.zero  <= rd_zero;
    end
  end

  always_ff @(posedge clk) begin
    rd_step_r <= step_r;
    if (rd_pend_r && !rd_step_r[0]) begin
      hi_r <= mem_rdata;
    end
    diff_r <= signed'({hi_r[31], hi_r}) - signed'({mem_rdata[31], mem_rdata});
  end

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_op == vgfd_pkg::OP_WRITE) begin
              if (wr_ok) begin
                state_r <= ST_WRITE;
              end
            end else if (qry_err) begin
              out_valid_r <= 1'b1;
              grad_x_r    <= '0;
              grad_y_r    <= '0;
              grad_z_r    <= '0;
              pos_error_r <= 1'b1;
            end else begin
              state_r <= ST_READ;
              step_r  <= '0;
            end
          end
        end
        ST_WRITE: begin
          state_r <= ST_IDLE;
        end
        ST_READ: begin
          step_r <= step_r + 3'd1;
          if (step_r == LAST_STEP) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (sc_ctl.valid && sc_ctl.axis == vgfd_pkg::AXIS_Z) begin
            out_valid_r <= 1'b1;
            grad_x_r    <= part_x_r;
            grad_y_r    <= part_y_r;
            grad_z_r    <= sc_value;
            pos_error_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
      endcase
      // Hold the finished x and y values until z arrives
      if (sc_ctl.valid && sc_ctl.axis == vgfd_pkg::AXIS_X) begin
        part_x_r <= sc_value;
      end
      if (sc_ctl.valid && sc_ctl.axis == vgfd_pkg::AXIS_Y) begin
        part_y_r <= sc_value;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_grad_x    = grad_x_r;
  assign out_grad_y    = grad_y_r;
  assign out_grad_z    = grad_z_r;
  assign out_pos_error = pos_error_r;

  // An error result carries zero gradients
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pos_error |-> out_grad_x == 0 && out_grad_y == 0 && out_grad_z == 0)
    else $error("error result with nonzero gradient");

  // The last axis only leaves the scaler while the sequencer waits for it
  a_z_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    sc_ctl.valid && sc_ctl.axis == vgfd_pkg::AXIS_Z |-> state_r == ST_DRAIN)
    else $error("last axis result outside drain");

  // A computed result follows the drain state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pos_error |-> $past(state_r) == ST_DRAIN)
    else $error("result strobe without drain");

  // No difference enters the scaler during a write
  a_no_diff_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |=> !dctl_r.valid)
    else $error("difference issued around a memory write");

endmodule

// ----- test/voxel_gradient_finite_difference_top_tb.sv -----
// Self-checking testbench for the voxel gradient unit: sample writes, gradient queries, registers.
`timescale 1ns / 100ps

module voxel_gradient_finite_difference_top_tb;

  localparam int MAX_SIZE      = 16;
  localparam int COMPONENTS    = 4;
  localparam int VOLUME_WORDS  = MAX_SIZE * MAX_SIZE * MAX_SIZE * COMPONENTS;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int SETTLE_CYCLES = 16;

  // One gradient beat as seen on the result ports.
  typedef struct packed {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
    logic               pos_error;
  } grad_t;

  // Mirror of the volume and registers; predicts and checks gradient beats.
  class grad_scoreboard;
    logic [31:0] voxel_mem [VOLUME_WORDS];
    bit          written   [VOLUME_WORDS];
    logic [4:0]  size_reg  [3];
    logic [31:0] inv_reg   [3];
    grad_t       expected_q [$];
    int          fail_count;
    int          n_writes;
    int          n_queries;
    int          n_outside;

    function new();
      for (int a = 0; a < 3; a++) begin
        size_reg[a] = 5'd1;
        inv_reg[a]  = 32'h0001_0000;
      end
    endfunction

    function void write_reg(vgfd_pkg::cfg_index_t idx, logic [31:0] data);
      case (idx)
        vgfd_pkg::CFG_SIZE_X:      size_reg[vgfd_pkg::AXIS_X] = data[4:0];
        vgfd_pkg::CFG_SIZE_Y:      size_reg[vgfd_pkg::AXIS_Y] = data[4:0];
        vgfd_pkg::CFG_SIZE_Z:      size_reg[vgfd_pkg::AXIS_Z] = data[4:0];
        vgfd_pkg::CFG_INV_SPACE_X: inv_reg[vgfd_pkg::AXIS_X]  = data;
        vgfd_pkg::CFG_INV_SPACE_Y: inv_reg[vgfd_pkg::AXIS_Y]  = data;
        vgfd_pkg::CFG_INV_SPACE_Z: inv_reg[vgfd_pkg::AXIS_Z]  = data;
        default: ;
      endcase
    endfunction

    // Clamp a size register to the volume edge.
    function int axis_len(int a);
      return (size_reg[a] > MAX_SIZE) ? MAX_SIZE : int'(size_reg[a]);
    endfunction

    function int word_addr(int x, int y, int z, int c);
      return ((z * MAX_SIZE + y) * MAX_SIZE + x) * COMPONENTS + c;
    endfunction

    function bit in_volume(int x, int y, int z);
      return x < axis_len(0) && y < axis_len(1) && z < axis_len(2);
    endfunction

    // True when this voxel and every neighbor that its gradient uses have been written.
    function bit can_query(int x, int y, int z, int c);
      int p[3];
      int q[3];
      int n;
      p = '{x, y, z};
      if (!written[word_addr(x, y, z, c)]) return 1'b0;
      for (int a = 0; a < 3; a++) begin
        n = axis_len(a);
        if (n > 1 && p[a] > 0) begin
          q = p;
          q[a] = p[a] - 1;
          if (!written[word_addr(q[0], q[1], q[2], c)]) return 1'b0;
        end
        if (n > 1 && p[a] < n - 1) begin
          q = p;
          q[a] = p[a] + 1;
          if (!written[word_addr(q[0], q[1], q[2], c)]) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // Scale a signed difference by an unsigned Q16.16 factor, truncate toward zero, saturate.
    function logic [31:0] scaled_diff(longint d, logic [31:0] inv, int sh);
      bit                neg;
      longint unsigned   mag;
      longint unsigned   prod;
      neg  = d < 0;
      mag  = neg ? longint'(-d) : d;
      prod = (mag * longint'({32'd0, inv})) >> sh;
      if (!neg) return (prod > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : prod[31:0];
      if (prod > 64'h8000_0000) prod = 64'h8000_0000;
      return 32'd0 - prod[31:0];
    endfunction

    // Derivative along one axis: one-sided at the ends, halved central difference inside.
    function logic [31:0] axis_slope(int x, int y, int z, int c, int a);
      int     hi[3];
      int     lo[3];
      int     n;
      int     sh;
      longint va;
      longint vb;
      n = axis_len(a);
      if (n <= 1) return 32'd0;
      hi = '{x, y, z};
      lo = hi;
      sh = 16;
      if (hi[a] == 0) begin
        hi[a] = hi[a] + 1;
      end else if (hi[a] == n - 1) begin
        lo[a] = lo[a] - 1;
      end else begin
        hi[a] = hi[a] + 1;
        lo[a] = lo[a] - 1;
        sh = 17;
      end
      va = $signed(voxel_mem[word_addr(hi[0], hi[1], hi[2], c)]);
      vb = $signed(voxel_mem[word_addr(lo[0], lo[1], lo[2], c)]);
      return scaled_diff(va - vb, inv_reg[a], sh);
    endfunction

    // Apply an accepted input beat: store a sample or queue the expected gradient.
    function void note_item(logic op, int x, int y, int z, int c, logic [31:0] value);
      grad_t g;
      if (op == vgfd_pkg::OP_WRITE) begin
        voxel_mem[word_addr(x, y, z, c)] = value;
        written[word_addr(x, y, z, c)]   = 1'b1;
        n_writes++;
        return;
      end
      n_queries++;
      if (!in_volume(x, y, z)) begin
        g = '{gx: '0, gy: '0, gz: '0, pos_error: 1'b1};
        n_outside++;
      end else begin
        g.gx        = axis_slope(x, y, z, c, 0);
        g.gy        = axis_slope(x, y, z, c, 1);
        g.gz        = axis_slope(x, y, z, c, 2);
        g.pos_error = 1'b0;
      end
      expected_q.push_back(g);
    endfunction

    // Compare a result beat with the oldest expected gradient.
    function void check_result(grad_t got);
      grad_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no query outstanding");
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      if (got.gx !== want.gx) begin
        $error("grad_x: expected %0d, got %0d", want.gx, got.gx);
        fail_count++;
      end
      if (got.gy !== want.gy) begin
        $error("grad_y: expected %0d, got %0d", want.gy, got.gy);
        fail_count++;
      end
      if (got.gz !== want.gz) begin
        $error("grad_z: expected %0d, got %0d", want.gz, got.gz);
        fail_count++;
      end
      if (got.pos_error !== want.pos_error) begin
        $error("pos_error: expected %0b, got %0b", want.pos_error, got.pos_error);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_op;
  logic [3:0]         in_pos_x;
  logic [3:0]         in_pos_y;
  logic [3:0]         in_pos_z;
  logic [1:0]         in_comp;
  logic signed [31:0] in_sample;
  logic               out_valid;
  logic signed [31:0] out_grad_x;
  logic signed [31:0] out_grad_y;
  logic signed [31:0] out_grad_z;
  logic               out_pos_error;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  grad_scoreboard sb;
  int             items_sent;
  int             regs_written;
  int             settings_used;
  bit             no_gaps;

  voxel_gradient_finite_difference_top #(
    .MAX_SIZE   (MAX_SIZE),
    .COMPONENTS (COMPONENTS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_comp       (in_comp),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_grad_x    (out_grad_x),
    .out_grad_y    (out_grad_y),
    .out_grad_z    (out_grad_z),
    .out_pos_error (out_pos_error),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watch all three channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result({out_grad_x, out_grad_y, out_grad_z, out_pos_error});
      if (start && !busy) sb.note_item(in_op, in_pos_x, in_pos_y, in_pos_z, in_comp, in_sample);
      if (cfg_valid && cfg_ready) sb.write_reg(vgfd_pkg::cfg_index_t'(cfg_index), cfg_data);
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    if (no_gaps) return 0;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6, 7: return 0;
      8, 9, 10, 11, 12:        return $urandom_range(1, 3);
      13, 14:                  return $urandom_range(4, 12);
      default:                 return $urandom_range(20, 40);
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [4:0] pick_size();
    case ($urandom_range(0, 29))
      0:       return 5'd0;
      1, 2:    return 5'd1;
      3, 4:    return 5'd16;
      5:       return 5'($urandom_range(17, 31));
      6, 7, 8: return 5'($urandom_range(2, 16));
      default: return 5'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic [31:0] pick_spacing();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1;
      3, 4:    return $urandom;
      default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
    endcase
  endfunction

  // Present one input beat and hold it until accepted; start stays high afterward.
  task automatic send_item(logic op, int x, int y, int z, int c, logic [31:0] value);
    int g;
    g = idle_cycles();
    if (g > 0) begin
      start = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_op     = op;
    in_pos_x  = x[3:0];
    in_pos_y  = y[3:0];
    in_pos_z  = z[3:0];
    in_comp   = c[1:0];
    in_sample = value;
    start     = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic store_sample(int x, int y, int z, int c, logic [31:0] value);
    send_item(vgfd_pkg::OP_WRITE, x, y, z, c, value);
  endtask

  task automatic query_grad(int x, int y, int z, int c);
    send_item(vgfd_pkg::OP_QUERY, x, y, z, c, $urandom);
  endtask

  // Rewrite a voxel now and then; always write one that was never written.
  task automatic store_fresh(int x, int y, int z, int c);
    if (!sb.written[sb.word_addr(x, y, z, c)] || $urandom_range(0, 1))
      store_sample(x, y, z, c, pick_sample());
  endtask

  // Fill the stencil around a voxel, then query its gradient.
  task automatic stencil_then_query(int x, int y, int z, int c);
    int p[3];
    int q[3];
    int n;
    p = '{x, y, z};
    store_fresh(x, y, z, c);
    for (int a = 0; a < 3; a++) begin
      n = sb.axis_len(a);
      if (n > 1 && p[a] > 0) begin
        q = p;
        q[a] = p[a] - 1;
        store_fresh(q[0], q[1], q[2], c);
      end
      if (n > 1 && p[a] < n - 1) begin
        q = p;
        q[a] = p[a] + 1;
        store_fresh(q[0], q[1], q[2], c);
      end
    end
    query_grad(x, y, z, c);
  endtask

  // Drop start and wait until every query has answered and the block is quiet.
  task automatic settle();
    start = 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(vgfd_pkg::cfg_index_t idx, logic [31:0] data);
    int g;
    g = idle_cycles();
    if (g > 0) begin
      cfg_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    regs_written++;
  endtask

  task automatic set_config(logic [4:0] sx, logic [4:0] sy, logic [4:0] sz,
                            logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
    settle();
    write_register(vgfd_pkg::CFG_SIZE_X, {27'd0, sx});
    write_register(vgfd_pkg::CFG_SIZE_Y, {27'd0, sy});
    write_register(vgfd_pkg::CFG_SIZE_Z, {27'd0, sz});
    write_register(vgfd_pkg::CFG_INV_SPACE_X, ix);
    write_register(vgfd_pkg::CFG_INV_SPACE_Y, iy);
    write_register(vgfd_pkg::CFG_INV_SPACE_Z, iz);
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  // One random step: noise write, stencil plus query, or a query anywhere.
  task automatic random_step();
    int kind;
    int x;
    int y;
    int z;
    int c;
    bit vol_empty;
    vol_empty = sb.axis_len(0) == 0 || sb.axis_len(1) == 0 || sb.axis_len(2) == 0;
    kind = $urandom_range(0, 19);
    c    = $urandom_range(0, COMPONENTS - 1);
    if (kind < 5) begin
      store_sample($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15), c,
                   pick_sample());
    end else if (kind < 15 && !vol_empty) begin
      stencil_then_query($urandom_range(0, sb.axis_len(0) - 1),
                         $urandom_range(0, sb.axis_len(1) - 1),
                         $urandom_range(0, sb.axis_len(2) - 1), c);
    end else begin
      if (!vol_empty && $urandom_range(0, 9) < 7) begin
        x = $urandom_range(0, sb.axis_len(0) - 1);
        y = $urandom_range(0, sb.axis_len(1) - 1);
        z = $urandom_range(0, sb.axis_len(2) - 1);
      end else begin
        x = $urandom_range(0, 15);
        y = $urandom_range(0, 15);
        z = $urandom_range(0, 15);
      end
      // Never read a word that was not written: build the stencil first.
      if (sb.in_volume(x, y, z) && !sb.can_query(x, y, z, c)) stencil_then_query(x, y, z, c);
      else query_grad(x, y, z, c);
    end
  endtask

  // Hard stop.
  initial begin
    #20_000_000;
    $display("voxel_gradient_finite_difference_top_tb: errors");
    $finish;
  end

  initial begin
    int random_base;
    int phase_end;
    sb            = new();
    items_sent    = 0;
    regs_written  = 0;
    settings_used = 0;
    no_gaps       = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_op         = vgfd_pkg::OP_WRITE;
    in_pos_x      = '0;
    in_pos_y      = '0;
    in_pos_z      = '0;
    in_comp       = '0;
    in_sample     = '0;
    cfg_valid     = 1'b0;
    cfg_index     = vgfd_pkg::CFG_SIZE_X;
    cfg_data      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset setting: all axes of size one give zero, anything off the origin is out of range.
    store_sample(0, 0, 0, 0, 32'h0001_0000);
    query_grad(0, 0, 0, 0);
    query_grad(0, 1, 0, 0);
    query_grad(15, 15, 15, 3);

    // Oversized x saturates to the full edge; last-voxel and first-voxel overflow both ways.
    set_config(5'd17, 5'd3, 5'd2, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0000);
    store_sample(15, 1, 0, 3, 32'h8000_0000);
    store_sample(14, 1, 0, 3, 32'h7FFF_FFFF);
    store_sample(15, 0, 0, 3, 32'h0000_0001);
    store_sample(15, 2, 0, 3, 32'hFFFF_FFFF);
    store_sample(15, 1, 1, 3, 32'h0000_0005);
    query_grad(15, 1, 0, 3);
    store_sample(0, 1, 0, 2, 32'h8000_0000);
    store_sample(1, 1, 0, 2, 32'h7FFF_FFFF);
    store_sample(0, 0, 0, 2, 32'hFFFD_0000);
    store_sample(0, 2, 0, 2, 32'h0004_0000);
    store_sample(0, 1, 1, 2, 32'h1234_5678);
    query_grad(0, 1, 0, 2);
    query_grad(0, 3, 0, 2);

    // A zero size makes every query out of range.
    set_config(5'd0, 5'd4, 5'd4, 32'h0000_0001, 32'h8000_0000, 32'h0000_8000);
    query_grad(0, 0, 0, 0);

    // Central difference along z would saturate without the halving; after it, the result stays in range.
    set_config(5'd2, 5'd1, 5'd5, 32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_C000);
    store_sample(1, 0, 2, 0, 32'h0003_0000);
    store_sample(0, 0, 2, 0, 32'hFFFF_0000);
    store_sample(1, 0, 1, 0, 32'h7FFF_FFFF);
    store_sample(1, 0, 3, 0, 32'h8000_0000);
    query_grad(1, 0, 2, 0);

    // Random phases, each with its own setting and idling mode.
    random_base = items_sent;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      set_config(pick_size(), pick_size(), pick_size(),
                 pick_spacing(), pick_spacing(), pick_spacing());
      no_gaps   = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + $urandom_range(80, 220);
      while (items_sent < phase_end) random_step();
    end

    settle();
    if (sb.expected_q.size() != 0) begin
      $error("%0d gradient results never arrived", sb.expected_q.size());
      sb.fail_count++;
    end
    $display("covered %0d input beats: %0d sample writes, %0d gradient queries, %0d out of range",
             items_sent, sb.n_writes, sb.n_queries, sb.n_outside);
    $display("covered %0d register writes over %0d settings", regs_written, settings_used);
    if (sb.fail_count == 0) begin
      $display("voxel_gradient_finite_difference_top_tb: clean");
    end else begin
      $display("voxel_gradient_finite_difference_top_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/vgfd_pkg.sv
hdl/vgfd_sample_mem.sv
hdl/vgfd_scale.sv
hdl/voxel_gradient_finite_difference_top.sv
test/voxel_gradient_finite_difference_top_tb.sv
